@@ design/cep_pkg.sv @@
// cep_pkg: shared types and codes for the comm primitive expander.
// Used by cep_front, cep_fifo, cep_back and comm_primitive_expander.
package cep_pkg;

	localparam int unsigned MaxSlicesDef = 16;
	localparam int unsigned QDepth       = 2;

	typedef enum logic [3:0] {
		OP_POST_READY       = 4'd0,
		OP_WAIT_READY       = 4'd1,
		OP_WAIT_FIN         = 4'd2,
		OP_POST_FIN         = 4'd3,
		OP_WAIT_FIN_ACK     = 4'd4,
		OP_POST_FIN_ACK     = 4'd5,
		OP_WRITE            = 4'd6,
		OP_WRITE_FIN        = 4'd7,
		OP_WRITE_REDUCE     = 4'd8,
		OP_WRITE_REDUCE_FIN = 4'd9,
		OP_READ             = 4'd10,
		OP_READ_REDUCE      = 4'd11,
		OP_LOCAL_REDUCE     = 4'd12
	} op_t;

	typedef enum logic [2:0] {
		CFG_WRITE_NOTIFY = 3'd0,
		CFG_POLL_CQ      = 3'd1,
		CFG_NET_INLINE   = 3'd2,
		CFG_TYPE_MASK    = 3'd3,
		CFG_OP_MASK      = 3'd4
	} cfg_idx_t;

	localparam logic [1:0] KIND_SEND     = 2'd0;
	localparam logic [1:0] KIND_RECV     = 2'd1;
	localparam logic [1:0] KIND_SEND_RED = 2'd2;
	localparam logic [1:0] KIND_RECV_RED = 2'd3;

	localparam logic [1:0] DMA_PUT = 2'd0;
	localparam logic [1:0] DMA_GET = 2'd1;

	localparam logic [1:0] LINK_P2P = 2'd0;
	localparam logic [1:0] LINK_NET = 2'd1;

	localparam logic [1:0] PROTO_OTHER = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ERR,
		PH_HEAD,
		PH_SLICE,
		PH_FIN,
		PH_ACK,
		PH_LOCAL
	} phase_t;

	typedef struct packed {
		logic        write_notify;
		logic        poll_cq;
		logic        net_inline;
		logic [15:0] type_mask;
		logic [7:0]  op_mask;
	} cfg_t;

	// one classified primitive
	typedef struct packed {
		logic        err;
		logic        active;
		logic        fused;
		logic        red;
		logic        ack;
		logic        local_red;
		op_t         data_op;
		op_t         fin_op;
		logic [4:0]  n;
		logic [15:0] rank;
		logic [3:0]  etype;
		logic [2:0]  redop;
	} plan_t;

	typedef struct packed {
		logic busy;
		logic q_valid;
	} back_status_t;

endpackage

@@ design/cep_front.sv @@
// cep_front: accepts primitives and classifies them into expansion plans.
// Depends on cep_pkg.
module cep_front import cep_pkg::*; #(
	parameter int unsigned MAX_SLICES = MaxSlicesDef
) (
	input  cfg_t        cfg,
	input  logic [1:0]  kind,
	input  logic [1:0]  dma_mode,
	input  logic [1:0]  link_kind,
	input  logic [1:0]  link_proto,
	input  logic [4:0]  slice_count,
	input  logic [15:0] peer_rank,
	input  logic [3:0]  elem_type,
	input  logic [2:0]  red_op,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        q_full,
	output logic        q_push,
	output plan_t       q_plan
);

	logic net, get, inl, notify;

	assign in_stall = q_full;
	// zero-slice primitives are taken and dropped
	assign q_push = in_valid && !q_full && (slice_count != 5'd0);

	always_comb begin
		net    = (link_kind == LINK_NET);
		case (dma_mode)
			DMA_PUT: get = 1'b0;
			DMA_GET: get = 1'b1;
			default: get = !net;
		endcase
		inl    = cfg.type_mask[elem_type] && cfg.op_mask[red_op] && (!net || cfg.net_inline);
		notify = net && cfg.write_notify;

		q_plan           = '0;
		q_plan.err       = !((link_kind == LINK_P2P) || (net && (link_proto != PROTO_OTHER)));
		q_plan.ack       = net && !cfg.poll_cq;
		q_plan.data_op   = OP_WRITE;
		q_plan.fin_op    = OP_WRITE;
		q_plan.n         = (slice_count > 5'(MAX_SLICES)) ? 5'(MAX_SLICES) : slice_count;
		q_plan.rank      = peer_rank;
		q_plan.etype     = elem_type;
		q_plan.redop     = red_op;

		case (kind)
			KIND_SEND: begin
				if (!get) begin
					q_plan.active  = 1'b1;
					q_plan.fin_op  = OP_WRITE_FIN;
					q_plan.fused   = notify;
				end
			end
			KIND_RECV: begin
				if (get) begin
					q_plan.active  = 1'b1;
					q_plan.data_op = OP_READ;
				end
			end
			KIND_SEND_RED: begin
				if (!get) begin
					q_plan.active = 1'b1;
					if (inl) begin
						q_plan.data_op = OP_WRITE_REDUCE;
						q_plan.fin_op  = OP_WRITE_REDUCE_FIN;
						q_plan.fused   = notify;
						q_plan.red     = 1'b1;
					end
				end
			end
			default: begin
				q_plan.active = get;
				if (inl) begin
					q_plan.data_op = OP_READ_REDUCE;
					q_plan.red     = 1'b1;
				end else begin
					q_plan.data_op   = OP_READ;
					q_plan.local_red = 1'b1;
				end
			end
		endcase
	end

endmodule

@@ design/cep_fifo.sv @@
// cep_fifo: short plan queue between front and back.
// Depends on cep_pkg.
module cep_fifo import cep_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  plan_t push_plan,
	output logic  full,
	input  logic  pop,
	output logic  valid,
	output plan_t pop_plan
);

	localparam int unsigned PtrW = $clog2(QDepth);
	localparam int unsigned CntW = $clog2(QDepth + 1);

	plan_t            entry_q [QDepth];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign full     = (count_q == CntW'(QDepth));
	assign valid    = (count_q != '0);
	assign pop_plan = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_plan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/cep_back.sv @@
// cep_back: sequencer that expands one plan into its run of micro-ops.
// Depends on cep_pkg; feeds a one-entry output register.
module cep_back import cep_pkg::*; #(
	parameter int unsigned MAX_SLICES = MaxSlicesDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  plan_t        q_plan,
	output logic         q_pop,
	output logic [3:0]   op_code,
	output logic [3:0]   slice_pos,
	output logic [15:0]  out_rank,
	output logic [3:0]   out_type,
	output logic [2:0]   out_redop,
	output logic         unsupported,
	output logic         last_op,
	output logic         out_valid,
	input  logic         out_stall,
	output back_status_t status
);

	localparam int unsigned CntW = $clog2(MAX_SLICES + 1);

	phase_t          phase_q, phase_d;
	logic [CntW-1:0] cnt_q, cnt_d;
	plan_t           plan_q;
	logic            adv, last_slice;
	phase_t          after_fin, after_ack;

	op_t             op_c;
	logic [3:0]      pos_c;
	logic            red_c, err_c;

	assign adv        = (phase_q != PH_IDLE) && (!out_valid || !out_stall);
	assign last_slice = (cnt_q == CntW'(plan_q.n - 5'd1));
	assign after_ack  = plan_q.local_red ? PH_LOCAL : PH_IDLE;
	assign after_fin  = plan_q.ack ? PH_ACK : after_ack;
	assign q_pop      = (phase_q == PH_IDLE) && q_valid;

	assign status.busy    = (phase_q != PH_IDLE);
	assign status.q_valid = q_valid;

	// next state
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		case (phase_q)
			PH_IDLE: begin
				if (q_valid) begin
					phase_d = q_plan.err ? PH_ERR : PH_HEAD;
					cnt_d   = '0;
				end
			end
			PH_ERR: begin
				if (adv) begin
					phase_d = PH_IDLE;
				end
			end
			PH_HEAD: begin
				if (adv) begin
					phase_d = plan_q.active ? PH_SLICE : PH_FIN;
				end
			end
			PH_SLICE: begin
				if (adv) begin
					if (last_slice) begin
						phase_d = plan_q.fused ? after_fin : PH_FIN;
						cnt_d   = '0;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			PH_FIN: begin
				if (adv) begin
					phase_d = after_fin;
				end
			end
			PH_ACK: begin
				if (adv) begin
					phase_d = after_ack;
				end
			end
			PH_LOCAL: begin
				if (adv) begin
					if (last_slice) begin
						phase_d = PH_IDLE;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// op selection
	always_comb begin
		op_c  = OP_POST_READY;
		pos_c = '0;
		red_c = 1'b0;
		err_c = 1'b0;
		case (phase_q)
			PH_ERR: err_c = 1'b1;
			PH_HEAD: op_c = plan_q.active ? OP_WAIT_READY : OP_POST_READY;
			PH_SLICE: begin
				op_c  = (plan_q.fused && last_slice) ? plan_q.fin_op : plan_q.data_op;
				pos_c = 4'(cnt_q);
				red_c = plan_q.red;
			end
			PH_FIN: op_c = plan_q.active ? OP_POST_FIN : OP_WAIT_FIN;
			PH_ACK: op_c = plan_q.active ? OP_WAIT_FIN_ACK : OP_POST_FIN_ACK;
			PH_LOCAL: begin
				op_c  = OP_LOCAL_REDUCE;
				pos_c = 4'(cnt_q);
				red_c = 1'b1;
			end
			default: op_c = OP_POST_READY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			if (adv) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			plan_q <= q_plan;
		end
		if (adv) begin
			op_code     <= op_c;
			slice_pos   <= pos_c;
			out_rank    <= plan_q.rank;
			out_type    <= red_c ? plan_q.etype : 4'd0;
			out_redop   <= red_c ? plan_q.redop : 3'd0;
			unsupported <= err_c;
			last_op     <= (phase_d == PH_IDLE);
		end
	end

endmodule

@@ design/comm_primitive_expander.sv @@
// comm_primitive_expander: top level, configuration registers and the
// front / queue / back split. Depends on cep_pkg, cep_front, cep_fifo, cep_back.
//
//  channel | direction | handshake          | payload
//  in      | in        | in_valid/in_stall   | kind .. red_op, one primitive
//  out     | out       | out_valid/out_stall | op_code .. last_op, one micro-op
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// The back sequencer gives one micro-op per cycle unless the output stalls: a
// primitive expands to up to 2*slices+3 micro-ops; an unsupported link to one.
// The front takes a primitive per cycle while the two-entry plan queue has room.
// Reset clears configuration, queue and sequencer; no clearing pass.
// A stalled output holds its micro-op and freezes a sequencer holding a plan.
module comm_primitive_expander import cep_pkg::*; #(
	parameter int unsigned MAX_SLICES = MaxSlicesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [1:0]  dma_mode,
	input  logic [1:0]  link_kind,
	input  logic [1:0]  link_proto,
	input  logic [4:0]  slice_count,
	input  logic [15:0] peer_rank,
	input  logic [3:0]  elem_type,
	input  logic [2:0]  red_op,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  op_code,
	output logic [3:0]  slice_pos,
	output logic [15:0] out_rank,
	output logic [3:0]  out_type,
	output logic [2:0]  out_redop,
	output logic        unsupported,
	output logic        last_op,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t         cfg_q;
	plan_t        push_plan, pop_plan;
	logic         q_push, q_pop, q_full, q_valid;
	back_status_t back_st;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WRITE_NOTIFY: cfg_q.write_notify <= cfg_data[0];
				CFG_POLL_CQ:      cfg_q.poll_cq      <= cfg_data[0];
				CFG_NET_INLINE:   cfg_q.net_inline   <= cfg_data[0];
				CFG_TYPE_MASK:    cfg_q.type_mask    <= cfg_data;
				CFG_OP_MASK:      cfg_q.op_mask      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	cep_front #(.MAX_SLICES(MAX_SLICES)) u_front (
		.cfg         (cfg_q),
		.kind        (kind),
		.dma_mode    (dma_mode),
		.link_kind   (link_kind),
		.link_proto  (link_proto),
		.slice_count (slice_count),
		.peer_rank   (peer_rank),
		.elem_type   (elem_type),
		.red_op      (red_op),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_plan      (push_plan)
	);

	cep_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_plan (push_plan),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_plan  (pop_plan)
	);

	cep_back #(.MAX_SLICES(MAX_SLICES)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_plan      (pop_plan),
		.q_pop       (q_pop),
		.op_code     (op_code),
		.slice_pos   (slice_pos),
		.out_rank    (out_rank),
		.out_type    (out_type),
		.out_redop   (out_redop),
		.unsupported (unsupported),
		.last_op     (last_op),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (back_st)
	);

	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unsupported |-> last_op && (op_code == OP_POST_READY) && (slice_pos == 4'd0))
		else $error("error result not alone in its run");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_op |-> back_st.busy)
		else $error("run ended without a last op");

	a_idle_pops: assert property (@(posedge clk) disable iff (!arst_n)
		!back_st.busy && back_st.q_valid |=> back_st.busy)
		else $error("queued plan not taken by idle sequencer");

endmodule

@@ tb/sv/cep_checker.sv @@
// cep_checker: watches the primitive, micro-op and register channels of the
// comm primitive expander, predicts each primitive's micro-op run and compares.
// Depends on cep_pkg for the op codes, register indexes and configuration type.
module cep_checker import cep_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [1:0]  dma_mode,
	input  logic [1:0]  link_kind,
	input  logic [1:0]  link_proto,
	input  logic [4:0]  slice_count,
	input  logic [15:0] peer_rank,
	input  logic [3:0]  elem_type,
	input  logic [2:0]  red_op,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  op_code,
	input  logic [3:0]  slice_pos,
	input  logic [15:0] out_rank,
	input  logic [3:0]  out_type,
	input  logic [2:0]  out_redop,
	input  logic        unsupported,
	input  logic        last_op,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int unsigned fail_count,
	output int unsigned pending_ops,
	output int unsigned ops_checked
);

	typedef struct packed {
		op_t         op;
		logic [3:0]  pos;
		logic [15:0] rank;
		logic [3:0]  etype;
		logic [2:0]  redop;
		logic        unsup;
		logic        last;
	} micro_op_t;

	micro_op_t   expected_ops[$];
	cfg_t        regs = '0;
	logic [15:0] cur_rank;
	logic [3:0]  cur_type;
	logic [2:0]  cur_redop;

	function automatic void queue_op(op_t op, logic [3:0] pos, logic with_red);
		micro_op_t m;
		m.op    = op;
		m.pos   = pos;
		m.rank  = cur_rank;
		m.etype = with_red ? cur_type : 4'd0;
		m.redop = with_red ? cur_redop : 3'd0;
		m.unsup = 1'b0;
		m.last  = 1'b0;
		expected_ops = {expected_ops, m};
	endfunction

	function automatic void mark_last(logic unsup);
		micro_op_t m;
		m = expected_ops[expected_ops.size() - 1];
		m.unsup = unsup;
		m.last  = 1'b1;
		expected_ops[expected_ops.size() - 1] = m;
	endfunction

	function automatic void waiting_side(logic ack);
		queue_op(OP_POST_READY, 4'd0, 1'b0);
		queue_op(OP_WAIT_FIN, 4'd0, 1'b0);
		if (ack) begin
			queue_op(OP_POST_FIN_ACK, 4'd0, 1'b0);
		end
	endfunction

	function automatic void driving_side(logic ack, int unsigned n, op_t op, op_t op_fin,
			logic fused, logic red);
		int unsigned p;
		queue_op(OP_WAIT_READY, 4'd0, 1'b0);
		if (fused) begin
			for (p = 0; p + 1 < n; p++) begin
				queue_op(op, 4'(p), red);
			end
			queue_op(op_fin, 4'(n - 1), red);
		end else begin
			for (p = 0; p < n; p++) begin
				queue_op(op, 4'(p), red);
			end
			queue_op(OP_POST_FIN, 4'd0, 1'b0);
		end
		if (ack) begin
			queue_op(OP_WAIT_FIN_ACK, 4'd0, 1'b0);
		end
	endfunction

	function automatic void expand_primitive(logic [1:0] k, logic [1:0] dm, logic [1:0] lk,
			logic [1:0] lp, logic [4:0] sc, logic [15:0] rank, logic [3:0] et, logic [2:0] ro);
		int unsigned n;
		int unsigned p;
		logic net, get, inl, notify, ack;
		cur_rank  = rank;
		cur_type  = et;
		cur_redop = ro;
		if (sc == 5'd0) begin
			return;
		end
		n   = (sc > MaxSlicesDef) ? MaxSlicesDef : int'(sc);
		net = (lk == LINK_NET);
		if (!(lk == LINK_P2P || (net && lp != PROTO_OTHER))) begin
			queue_op(OP_POST_READY, 4'd0, 1'b0);
			mark_last(1'b1);
			return;
		end
		case (dm)
			DMA_PUT: get = 1'b0;
			DMA_GET: get = 1'b1;
			default: get = !net;
		endcase
		inl    = regs.type_mask[et] && regs.op_mask[ro] && (!net || regs.net_inline);
		notify = net && regs.write_notify;
		ack    = net && !regs.poll_cq;
		case (k)
			KIND_SEND: begin
				if (get) waiting_side(ack);
				else driving_side(ack, n, OP_WRITE, OP_WRITE_FIN, notify, 1'b0);
			end
			KIND_RECV: begin
				if (get) driving_side(ack, n, OP_READ, OP_READ, 1'b0, 1'b0);
				else waiting_side(ack);
			end
			KIND_SEND_RED: begin
				if (get) waiting_side(ack);
				else if (inl) driving_side(ack, n, OP_WRITE_REDUCE, OP_WRITE_REDUCE_FIN, notify, 1'b1);
				else driving_side(ack, n, OP_WRITE, OP_WRITE, 1'b0, 1'b0);
			end
			default: begin
				if (!get) waiting_side(ack);
				else if (inl) driving_side(ack, n, OP_READ_REDUCE, OP_READ_REDUCE, 1'b0, 1'b1);
				else driving_side(ack, n, OP_READ, OP_READ, 1'b0, 1'b0);
				// no inline reduction: reduce each slice locally afterwards
				if (!inl) begin
					for (p = 0; p < n; p++) begin
						queue_op(OP_LOCAL_REDUCE, 4'(p), 1'b1);
					end
				end
			end
		endcase
		mark_last(1'b0);
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		micro_op_t want;
		if (!arst_n) begin
			regs = '0;
			expected_ops.delete();
			pending_ops = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_WRITE_NOTIFY: regs.write_notify = cfg_data[0];
					CFG_POLL_CQ:      regs.poll_cq      = cfg_data[0];
					CFG_NET_INLINE:   regs.net_inline   = cfg_data[0];
					CFG_TYPE_MASK:    regs.type_mask    = cfg_data;
					CFG_OP_MASK:      regs.op_mask      = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				expand_primitive(kind, dma_mode, link_kind, link_proto, slice_count,
					peer_rank, elem_type, red_op);
			end
			if (out_valid && !out_stall) begin
				if (expected_ops.size() == 0) begin
					$error("op_code: expected no transfer, got 0x%0h", op_code);
					fail_count++;
				end else begin
					want = expected_ops.pop_front();
					ops_checked++;
					check_field("op_code", 16'(want.op), 16'(op_code));
					check_field("slice_pos", 16'(want.pos), 16'(slice_pos));
					check_field("out_rank", want.rank, out_rank);
					check_field("out_type", 16'(want.etype), 16'(out_type));
					check_field("out_redop", 16'(want.redop), 16'(out_redop));
					check_field("unsupported", 16'(want.unsup), 16'(unsupported));
					check_field("last_op", 16'(want.last), 16'(last_op));
				end
			end
			pending_ops = expected_ops.size();
		end
	end

endmodule

@@ tb/sv/tb.sv @@
// tb: stimulus and verdict for comm_primitive_expander; directed primitives,
// then randomised phases under varied register settings and pacing.
// Depends on cep_pkg, comm_primitive_expander and cep_checker.
module tb import cep_pkg::*; ();

	localparam logic [1:0] DMA_DEFAULT   = 2'd2;
	localparam logic [1:0] DMA_UNDEF     = 2'd3;
	localparam logic [1:0] LINK_OTHER    = 2'd2;
	localparam logic [1:0] LINK_UNDEF    = 2'd3;
	localparam logic [1:0] PROTO_ROCE    = 2'd0;
	localparam logic [1:0] PROTO_UB_CTP  = 2'd1;
	localparam logic [1:0] PROTO_UB_TP   = 2'd2;
	localparam logic [2:0] CFG_IDX_SPARE = 3'd7;
	localparam int unsigned QuietLimit   = 2000;
	localparam int unsigned HoldCycles   = 80;
	localparam int unsigned PhaseItems   = 55;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [1:0]  dma_mode;
	logic [1:0]  link_kind;
	logic [1:0]  link_proto;
	logic [4:0]  slice_count;
	logic [15:0] peer_rank;
	logic [3:0]  elem_type;
	logic [2:0]  red_op;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  op_code;
	logic [3:0]  slice_pos;
	logic [15:0] out_rank;
	logic [3:0]  out_type;
	logic [2:0]  out_redop;
	logic        unsupported;
	logic        last_op;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	int unsigned fail_count;
	int unsigned pending_ops;
	int unsigned ops_checked;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_requested = 0;
	int unsigned hold_served = 0;
	int unsigned prims_sent = 0;
	int unsigned reg_writes = 0;

	comm_primitive_expander i_dut (.*);
	cep_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : receiver
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_requested) begin
				out_stall = 1'b1;
				repeat (HoldCycles) @(negedge clk);
				hold_served++;
			end
			out_stall = ($urandom_range(99) < recv_idle_pct);
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	task automatic offer_primitive(input logic [1:0] k, input logic [1:0] dm,
			input logic [1:0] lk, input logic [1:0] lp, input logic [4:0] n,
			input logic [15:0] rank, input logic [3:0] et, input logic [2:0] ro);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		kind        = k;
		dma_mode    = dm;
		link_kind   = lk;
		link_proto  = lp;
		slice_count = n;
		peer_rank   = rank;
		elem_type   = et;
		red_op      = ro;
		in_valid    = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		prims_sent++;
	endtask

	task automatic random_primitive();
		logic [1:0] lk, lp;
		logic [4:0] n;
		// mostly supported links and in-range slice counts, the rest is noise
		if ($urandom_range(99) < 85) begin
			lk = $urandom_range(1) ? LINK_NET : LINK_P2P;
			lp = 2'($urandom_range(2));
			n  = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16, 1));
		end else begin
			lk = 2'($urandom_range(3));
			lp = 2'($urandom_range(3));
			n  = 5'($urandom_range(31));
		end
		offer_primitive(2'($urandom_range(3)), 2'($urandom_range(3)), lk, lp, n,
			16'($urandom), 4'($urandom), 3'($urandom));
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		reg_writes++;
	endtask

	task automatic set_config(input logic [15:0] notify, input logic [15:0] poll,
			input logic [15:0] net_inl, input logic [15:0] tmask, input logic [15:0] omask);
		write_reg(CFG_WRITE_NOTIFY, notify);
		write_reg(CFG_POLL_CQ, poll);
		write_reg(CFG_NET_INLINE, net_inl);
		write_reg(CFG_TYPE_MASK, tmask);
		write_reg(CFG_OP_MASK, omask);
	endtask

	// wait for every expected micro-op, then hold the inputs idle before going on
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_ops != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin : stimulus
		int unsigned ph;
		int unsigned i;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		kind        = KIND_SEND;
		dma_mode    = DMA_PUT;
		link_kind   = LINK_P2P;
		link_proto  = PROTO_ROCE;
		slice_count = 5'd0;
		peer_rank   = 16'd0;
		elem_type   = 4'd0;
		red_op      = 3'd0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_WRITE_NOTIFY;
		cfg_data    = 16'd0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 28;
		recv_idle_pct = 74;

		// registers at reset: no notify, fin-acks on network links, no inline reduce
		offer_primitive(KIND_SEND, DMA_PUT, LINK_P2P, PROTO_ROCE, 5'd1, 16'h0000, 4'd0, 3'd0);
		offer_primitive(KIND_RECV, DMA_GET, LINK_P2P, PROTO_OTHER, 5'd16, 16'hFFFF, 4'd15, 3'd7);
		offer_primitive(KIND_RECV, DMA_PUT, LINK_P2P, PROTO_ROCE, 5'd0, 16'h1234, 4'd3, 3'd2);
		offer_primitive(KIND_SEND, DMA_PUT, LINK_OTHER, PROTO_ROCE, 5'd3, 16'hA5A5, 4'd9, 3'd5);
		offer_primitive(KIND_RECV_RED, DMA_GET, LINK_UNDEF, PROTO_ROCE, 5'd31, 16'h5A5A, 4'd6, 3'd1);
		offer_primitive(KIND_SEND_RED, DMA_PUT, LINK_NET, PROTO_OTHER, 5'd5, 16'h00FF, 4'd2, 3'd3);
		offer_primitive(KIND_SEND, DMA_PUT, LINK_UNDEF, PROTO_OTHER, 5'd0, 16'hFF00, 4'd1, 3'd4);
		offer_primitive(KIND_RECV_RED, DMA_UNDEF, LINK_NET, PROTO_UB_TP, 5'd31, 16'h8001, 4'd15, 3'd7);
		offer_primitive(KIND_SEND_RED, DMA_DEFAULT, LINK_P2P, PROTO_UB_CTP, 5'd4, 16'h7FFE, 4'd5, 3'd6);
		offer_primitive(KIND_SEND, DMA_PUT, LINK_NET, PROTO_UB_CTP, 5'd2, 16'h0F0F, 4'd8, 3'd0);
		offer_primitive(KIND_RECV, DMA_DEFAULT, LINK_NET, PROTO_ROCE, 5'd1, 16'hF0F0, 4'd4, 3'd1);
		offer_primitive(KIND_SEND_RED, DMA_PUT, LINK_P2P, PROTO_ROCE, 5'd3, 16'h3C3C, 4'd7, 3'd2);
		offer_primitive(KIND_RECV_RED, DMA_GET, LINK_P2P, PROTO_ROCE, 5'd2, 16'hC3C3, 4'd10, 3'd3);
		settle();

		// every capability on, with spare register bits set
		set_config(16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		write_reg(CFG_IDX_SPARE, 16'hFFFF);
		offer_primitive(KIND_SEND, DMA_PUT, LINK_NET, PROTO_ROCE, 5'd17, 16'h0001, 4'd0, 3'd0);
		offer_primitive(KIND_SEND_RED, DMA_PUT, LINK_NET, PROTO_UB_TP, 5'd16, 16'hBEEF, 4'd15, 3'd7);
		offer_primitive(KIND_SEND_RED, DMA_PUT, LINK_P2P, PROTO_ROCE, 5'd1, 16'h4321, 4'd11, 3'd5);
		offer_primitive(KIND_RECV_RED, DMA_GET, LINK_P2P, PROTO_OTHER, 5'd16, 16'hCAFE, 4'd12, 3'd6);
		offer_primitive(KIND_RECV_RED, DMA_PUT, LINK_NET, PROTO_UB_CTP, 5'd3, 16'h2468, 4'd13, 3'd4);
		offer_primitive(KIND_SEND, DMA_PUT, LINK_NET, PROTO_UB_CTP, 5'd1, 16'h1357, 4'd14, 3'd3);
		offer_primitive(KIND_SEND_RED, DMA_PUT, LINK_NET, PROTO_ROCE, 5'd1, 16'h9999, 4'd1, 3'd2);
		settle();

		// partial masks, network inline reduction off
		set_config(16'h0001, 16'hFFFE, 16'h0000, 16'h8001, 16'h0081);
		offer_primitive(KIND_SEND_RED, DMA_PUT, LINK_P2P, PROTO_ROCE, 5'd2, 16'h0101, 4'd0, 3'd0);
		offer_primitive(KIND_SEND_RED, DMA_PUT, LINK_NET, PROTO_ROCE, 5'd2, 16'h0202, 4'd0, 3'd0);
		offer_primitive(KIND_RECV_RED, DMA_GET, LINK_P2P, PROTO_ROCE, 5'd2, 16'h0303, 4'd15, 3'd6);
		offer_primitive(KIND_SEND, DMA_PUT, LINK_NET, PROTO_UB_TP, 5'd2, 16'h0404, 4'd2, 3'd1);
		settle();

		for (ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin
					send_idle_pct = 28;
					recv_idle_pct = 74;
				end
				1: begin
					send_idle_pct = 74;
					recv_idle_pct = 28;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (ph)
				1: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
				default: set_config(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom));
			endcase
			for (i = 0; i < PhaseItems; i++) begin
				// long receiver hold-off while primitives keep coming
				if (ph == 4 && i == 5)
					hold_requested++;
				random_primitive();
			end
			settle();
		end

		$display("Sent %0d primitives (directed and random) across %0d register writes,",
			prims_sent, reg_writes);
		$display("checked %0d micro-ops under three pacing modes and a long output hold-off.",
			ops_checked);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
design/cep_pkg.sv
design/cep_front.sv
design/cep_fifo.sv
design/cep_back.sv
design/comm_primitive_expander.sv
tb/sv/cep_checker.sv
tb/sv/tb.sv
